### sv/aeps_pkg.sv
// ----------------------------------------------------------------------------
// aeps_pkg
// Shared types, codes and helpers of the active/expired priority scheduler.
// ----------------------------------------------------------------------------
package aeps_pkg;

    localparam int MAX_TASKS_DEF   = 16;
    localparam int PRIO_LEVELS_DEF = 40;
    localparam int NICE_BASE       = 100;
    localparam logic [7:0] DEF_QUANTUM = 8'd2;

    // Operation codes of the input item.
    localparam logic [2:0] FN_CREATE = 3'd0;
    localparam logic [2:0] FN_TICK   = 3'd1;
    localparam logic [2:0] FN_BLOCK  = 3'd2;
    localparam logic [2:0] FN_NICE   = 3'd3;
    localparam logic [2:0] FN_KILL   = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    typedef enum logic [1:0] {
        RS_READY    = 2'd0,
        RS_RUN      = 2'd1,
        RS_BLOCKED  = 2'd2,
        RS_RBLOCKED = 2'd3
    } run_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_FULL,
        OP_CREATE,
        OP_ENQ_RD,
        OP_ENQ_WR,
        OP_SC_INIT,
        OP_SWAP0,
        OP_Q_RD,
        OP_LOAD_HEAD,
        OP_LVL_INC,
        OP_SET_INC,
        OP_SC_BLK,
        OP_SC_NEXT,
        OP_TK_UPD,
        OP_TK_EXP,
        OP_TK_END,
        OP_F_HIT,
        OP_F_STEP,
        OP_BLOCK,
        OP_OK,
        OP_NICE_EQ,
        OP_UNL_RD,
        OP_UNL_WR,
        OP_SWAP,
        OP_KILL_END,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        logic [2:0] func;
        logic       kself;
        logic       nlev_ok;
        logic       run_nil;
        logic       free_none;
        logic       sp_nil;
        logic       sp_blocked;
        logic       sp_match;
        logic       ticks_zero;
        logic       lvl_last;
        logic       set_one;
        logic       nice_same;
        logic       hd_nil;
        logic       out_busy;
    } dp_stat_t;

    // Quantum granted to a task, saturated to eight bits.
    function automatic logic [7:0] quantum(input logic [15:0] id, input logic [7:0] live,
                                           input logic [7:0] dq);
        logic [9:0] q;
        if (id == 16'd0) q = 10'd2 + {1'b0, live, 1'b0};
        else if (id == 16'd1) q = 10'd1;
        else if (id == 16'd2) q = 10'd2 + {2'b00, live};
        else q = {2'b00, dq};
        return (q > 10'd255) ? 8'hFF : q[7:0];
    endfunction

endpackage

### sv/aeps_ctrl.sv
// ----------------------------------------------------------------------------
// aeps_ctrl
// Sequencer of the scheduler: walks queues and chains one step per cycle.
// ----------------------------------------------------------------------------
module aeps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  aeps_pkg::dp_stat_t stat,
    output aeps_pkg::dp_op_t  op
);
    import aeps_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_CR, S_EQ0, S_EQ1, S_SC0, S_SC1, S_SC2, S_SC3,
        S_TK1, S_TK2, S_TK3, S_TK4, S_TK5, S_TKE, S_FI0, S_FI1, S_FI2,
        S_BLK, S_NI, S_NI1, S_UN0, S_UN1, S_KL0, S_KL1, S_KL2, S_KLE, S_FIN
    } state_t;

    state_t state_reg, state_next;
    state_t enq_ret_reg, enq_ret_next;
    state_t scan_ret_reg, scan_ret_next;
    state_t unl_ret_reg, unl_ret_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        enq_ret_next  = enq_ret_reg;
        scan_ret_next = scan_ret_reg;
        unl_ret_next  = unl_ret_reg;
        op            = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_ACCEPT;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.func)
                    FN_CREATE: state_next = S_CR;
                    FN_TICK:
                    begin
                        op            = OP_SC_INIT;
                        scan_ret_next = S_TK1;
                        state_next    = S_SC0;
                    end
                    FN_BLOCK:
                    begin
                        op         = OP_SC_INIT;
                        state_next = S_FI0;
                    end
                    FN_NICE:
                    begin
                        if (stat.nlev_ok)
                        begin
                            op         = OP_SC_INIT;
                            state_next = S_FI0;
                        end
                        else state_next = S_FIN;
                    end
                    FN_KILL:
                    begin
                        if (stat.kself && stat.run_nil) state_next = S_FIN;
                        else
                        begin
                            op         = OP_SC_INIT;
                            state_next = S_FI0;
                        end
                    end
                    default: state_next = S_FIN;
                endcase
            end
            S_CR:
            begin
                if (stat.free_none)
                begin
                    op         = OP_FULL;
                    state_next = S_FIN;
                end
                else
                begin
                    op           = OP_CREATE;
                    enq_ret_next = S_FIN;
                    state_next   = S_EQ0;
                end
            end
            S_EQ0:
            begin
                op         = OP_ENQ_RD;
                state_next = S_EQ1;
            end
            S_EQ1:
            begin
                op         = OP_ENQ_WR;
                state_next = enq_ret_reg;
            end
            S_SC0:
            begin
                op         = OP_Q_RD;
                state_next = S_SC1;
            end
            S_SC1:
            begin
                op         = OP_LOAD_HEAD;
                state_next = S_SC2;
            end
            S_SC2:
            begin
                if (stat.sp_nil)
                begin
                    if (stat.lvl_last) state_next = scan_ret_reg;
                    else
                    begin
                        op         = OP_LVL_INC;
                        state_next = S_SC0;
                    end
                end
                else if (stat.sp_blocked)
                begin
                    // Blocked heads leave for the expired set before the search goes on.
                    op           = OP_SC_BLK;
                    enq_ret_next = S_SC3;
                    state_next   = S_EQ0;
                end
                else state_next = scan_ret_reg;
            end
            S_SC3:
            begin
                op         = OP_SC_NEXT;
                state_next = S_SC2;
            end
            S_TK1:
            begin
                if (stat.sp_nil)
                begin
                    op            = OP_SWAP0;
                    scan_ret_next = S_TK2;
                    state_next    = S_SC0;
                end
                else state_next = S_TK2;
            end
            S_TK2:
            begin
                if (stat.sp_nil) state_next = S_TKE;
                else
                begin
                    op         = OP_TK_UPD;
                    state_next = S_TK3;
                end
            end
            S_TK3:
            begin
                if (stat.ticks_zero)
                begin
                    op           = OP_TK_EXP;
                    enq_ret_next = S_TK4;
                    state_next   = S_EQ0;
                end
                else state_next = S_TKE;
            end
            S_TK4:
            begin
                scan_ret_next = S_TK5;
                state_next    = S_SC0;
            end
            S_TK5:
            begin
                if (stat.sp_nil)
                begin
                    op            = OP_SWAP0;
                    scan_ret_next = S_TKE;
                    state_next    = S_SC0;
                end
                else state_next = S_TKE;
            end
            S_TKE:
            begin
                op         = OP_TK_END;
                state_next = S_FIN;
            end
            S_FI0:
            begin
                op         = OP_Q_RD;
                state_next = S_FI1;
            end
            S_FI1:
            begin
                op         = OP_LOAD_HEAD;
                state_next = S_FI2;
            end
            S_FI2:
            begin
                if (stat.sp_nil)
                begin
                    if (!stat.lvl_last)
                    begin
                        op         = OP_LVL_INC;
                        state_next = S_FI0;
                    end
                    else if (!stat.set_one)
                    begin
                        op         = OP_SET_INC;
                        state_next = S_FI0;
                    end
                    else state_next = S_FIN;
                end
                else if (stat.sp_match)
                begin
                    op = OP_F_HIT;
                    if (stat.func == FN_BLOCK) state_next = S_BLK;
                    else if (stat.func == FN_NICE) state_next = S_NI;
                    else
                    begin
                        unl_ret_next = S_KL0;
                        state_next   = S_UN0;
                    end
                end
                else
                begin
                    op         = OP_F_STEP;
                    state_next = S_FI2;
                end
            end
            S_BLK:
            begin
                op         = OP_BLOCK;
                state_next = S_FIN;
            end
            S_NI:
            begin
                if (stat.nice_same)
                begin
                    op         = OP_OK;
                    state_next = S_FIN;
                end
                else
                begin
                    unl_ret_next = S_NI1;
                    state_next   = S_UN0;
                end
            end
            S_NI1:
            begin
                op           = OP_NICE_EQ;
                enq_ret_next = S_FIN;
                state_next   = S_EQ0;
            end
            S_UN0:
            begin
                op         = OP_UNL_RD;
                state_next = S_UN1;
            end
            S_UN1:
            begin
                op         = OP_UNL_WR;
                state_next = unl_ret_reg;
            end
            S_KL0:
            begin
                op         = OP_SC_INIT;
                state_next = S_KL1;
            end
            S_KL1:
            begin
                op         = OP_Q_RD;
                state_next = S_KL2;
            end
            S_KL2:
            begin
                if (!stat.hd_nil) state_next = S_KLE;
                else if (stat.lvl_last)
                begin
                    op         = OP_SWAP;
                    state_next = S_KLE;
                end
                else
                begin
                    op         = OP_LVL_INC;
                    state_next = S_KL1;
                end
            end
            S_KLE:
            begin
                op         = OP_KILL_END;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    op         = OP_LOAD_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            enq_ret_reg  <= S_FIN;
            scan_ret_reg <= S_FIN;
            unl_ret_reg  <= S_FIN;
        end
        else
        begin
            state_reg    <= state_next;
            enq_ret_reg  <= enq_ret_next;
            scan_ret_reg <= scan_ret_next;
            unl_ret_reg  <= unl_ret_next;
        end
    end

endmodule

### sv/aeps_dp.sv
// ----------------------------------------------------------------------------
// aeps_dp
// Datapath: slot table, queue head/tail memories, cursors and result registers.
// ----------------------------------------------------------------------------
module aeps_dp #(
    parameter int MAX_TASKS   = 16,
    parameter int PRIO_LEVELS = 40
) (
    input  logic               clk,
    input  logic               rst_n,
    input  aeps_pkg::dp_op_t   op,
    output aeps_pkg::dp_stat_t stat,
    input  logic [2:0]         func,
    input  logic [15:0]        task_id,
    input  logic               kill_self,
    input  logic [63:0]        context_word,
    input  logic [7:0]         nice_level,
    input  logic               yield_now,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [15:0]        result_id,
    output logic [63:0]        next_context,
    output logic               reschedule
);
    import aeps_pkg::*;

    localparam int SW = $clog2(MAX_TASKS);
    localparam int PW = $clog2(MAX_TASKS + 1);
    localparam int LW = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
    localparam int NQ = 2 * PRIO_LEVELS;
    localparam int QW = $clog2(NQ);
    localparam logic [PW-1:0] NIL = PW'(MAX_TASKS);

    function automatic logic [QW-1:0] qidx(input logic b, input logic [LW-1:0] l);
        return b ? (QW'(PRIO_LEVELS) + QW'(l)) : QW'(l);
    endfunction

    // Latched item and result.
    logic [2:0]  func_reg;
    logic [15:0] tid_reg;
    logic        kself_reg;
    logic [63:0] ctx_reg;
    logic [7:0]  nlev_reg;
    logic        yld_reg;
    logic [1:0]  rs_reg;
    logic [15:0] rid_reg;
    logic [63:0] rctx_reg;
    logic        rres_reg;
    logic        ov_reg;
    logic [1:0]  ost_reg;
    logic [15:0] oid_reg;
    logic [63:0] octx_reg;
    logic        ores_reg;

    // Scheduler state.
    logic [7:0]    dq_reg;
    logic          bank_reg;
    logic [15:0]   idc_reg;
    logic [PW-1:0] live_reg, run_reg;

    // Cursors.
    logic [PW-1:0] sp_reg, prev_reg, nx_reg;
    logic [LW-1:0] lvl_reg, flvl_reg;
    logic          set_reg, fset_reg;
    logic [QW-1:0] fq_reg, eq_reg;

    // Slot table.
    logic          sv_reg   [MAX_TASKS];
    logic [15:0]   sid_reg  [MAX_TASKS];
    run_state_t    sst_reg  [MAX_TASKS];
    logic [7:0]    stk_reg  [MAX_TASKS];
    logic [63:0]   sctx_reg [MAX_TASKS];
    logic [PW-1:0] slk_reg  [MAX_TASKS];

    // Queue memories with per-entry valid bits; an unwritten entry reads as null.
    logic [PW-1:0] head_reg [NQ];
    logic [PW-1:0] tail_reg [NQ];
    logic          hv_reg   [NQ];
    logic          tv_reg   [NQ];
    logic [PW-1:0] hd_raw_reg, tl_raw_reg;
    logic          hd_vld_reg, tl_vld_reg;

    logic [PW-1:0] hd, tl, free_slot, c_lk;
    logic [SW-1:0] sp_i, tl_i, prev_i, free_i;
    logic [15:0]   c_id;
    run_state_t    c_st;
    logic [7:0]    c_tk, quant, quant_new, live8;
    logic [63:0]   c_ctx;
    logic [QW-1:0] qa, ra;
    logic [LW-1:0] nl;
    logic          rd_en, hw_en, tw_en;
    logic [QW-1:0] hw_a, tw_a;
    logic [PW-1:0] hw_d, tw_d;

    assign hd     = hd_vld_reg ? hd_raw_reg : NIL;
    assign tl     = tl_vld_reg ? tl_raw_reg : NIL;
    assign sp_i   = sp_reg[SW-1:0];
    assign tl_i   = tl[SW-1:0];
    assign prev_i = prev_reg[SW-1:0];
    assign free_i = free_slot[SW-1:0];
    assign c_id   = sid_reg[sp_i];
    assign c_st   = sst_reg[sp_i];
    assign c_tk   = stk_reg[sp_i];
    assign c_ctx  = sctx_reg[sp_i];
    assign c_lk   = slk_reg[sp_i];
    assign live8  = 8'(live_reg);
    assign quant     = quantum(c_id, live8, dq_reg);
    assign quant_new = quantum(idc_reg, live8, dq_reg);
    assign qa = qidx(bank_reg ^ set_reg, lvl_reg);
    assign nl = LW'(nlev_reg - 8'(NICE_BASE));

    always_comb
    begin
        free_slot = NIL;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
            if (!sv_reg[i]) free_slot = PW'(i);
    end

    assign rd_en = (op == OP_Q_RD) || (op == OP_ENQ_RD) || (op == OP_UNL_RD);

    always_comb
    begin
        unique case (op)
            OP_ENQ_RD: ra = eq_reg;
            OP_UNL_RD: ra = fq_reg;
            default:   ra = qa;
        endcase
    end

    always_comb
    begin
        hw_en = 1'b0;
        hw_a  = qa;
        hw_d  = NIL;
        tw_en = 1'b0;
        tw_a  = qa;
        tw_d  = NIL;
        unique case (op)
            OP_ENQ_WR:
            begin
                hw_a  = eq_reg;
                hw_d  = sp_reg;
                hw_en = (tl == NIL);
                tw_a  = eq_reg;
                tw_d  = sp_reg;
                tw_en = 1'b1;
            end
            OP_SC_BLK, OP_TK_EXP:
            begin
                // Pop the head of the current active queue.
                hw_d  = c_lk;
                hw_en = 1'b1;
                tw_en = (c_lk == NIL);
            end
            OP_UNL_WR:
            begin
                hw_a  = fq_reg;
                hw_d  = c_lk;
                hw_en = (prev_reg == NIL);
                tw_a  = fq_reg;
                tw_d  = prev_reg;
                tw_en = (tl == sp_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hw_en) head_reg[hw_a] <= hw_d;
        if (tw_en) tail_reg[tw_a] <= tw_d;
        if (rd_en)
        begin
            hd_raw_reg <= head_reg[ra];
            tl_raw_reg <= tail_reg[ra];
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NQ; i++)
            begin
                hv_reg[i] <= 1'b0;
                tv_reg[i] <= 1'b0;
            end
            for (int i = 0; i < MAX_TASKS; i++) sv_reg[i] <= 1'b0;
            hd_vld_reg <= 1'b0;
            tl_vld_reg <= 1'b0;
            dq_reg     <= DEF_QUANTUM;
            bank_reg   <= 1'b0;
            idc_reg    <= 16'd0;
            live_reg   <= '0;
            run_reg    <= NIL;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we) dq_reg <= cfg_wdata;
            if (hw_en) hv_reg[hw_a] <= 1'b1;
            if (tw_en) tv_reg[tw_a] <= 1'b1;
            if (rd_en)
            begin
                hd_vld_reg <= hv_reg[ra];
                tl_vld_reg <= tv_reg[ra];
            end
            if (op == OP_LOAD_OUT) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
            unique case (op)
                OP_CREATE:
                begin
                    sv_reg[free_i] <= 1'b1;
                    idc_reg        <= idc_reg + 16'd1;
                    live_reg       <= live_reg + PW'(1);
                end
                OP_SWAP0, OP_SWAP: bank_reg <= ~bank_reg;
                OP_TK_END: run_reg <= sp_reg;
                OP_KILL_END:
                begin
                    sv_reg[sp_i] <= 1'b0;
                    if (live_reg != '0) live_reg <= live_reg - PW'(1);
                    if (run_reg == sp_reg) run_reg <= NIL;
                end
                default: ;
            endcase
        end
    end

    // Payload and table contents.
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_ACCEPT:
            begin
                func_reg  <= func;
                tid_reg   <= task_id;
                kself_reg <= kill_self;
                ctx_reg   <= context_word;
                nlev_reg  <= nice_level;
                yld_reg   <= yield_now;
                rs_reg    <= ST_IGNORED;
                rid_reg   <= 16'd0;
                rctx_reg  <= 64'd0;
                rres_reg  <= 1'b0;
            end
            OP_FULL: rs_reg <= ST_FULL;
            OP_CREATE:
            begin
                sp_reg           <= free_slot;
                sid_reg[free_i]  <= idc_reg;
                sctx_reg[free_i] <= ctx_reg;
                stk_reg[free_i]  <= quant_new;
                sst_reg[free_i]  <= RS_READY;
                rid_reg          <= idc_reg;
                rs_reg           <= ST_OK;
                eq_reg           <= qidx(bank_reg, '0);
            end
            OP_ENQ_RD: slk_reg[sp_i] <= NIL;
            OP_ENQ_WR: if (tl != NIL) slk_reg[tl_i] <= sp_reg;
            OP_SC_INIT:
            begin
                lvl_reg  <= '0;
                set_reg  <= 1'b0;
                prev_reg <= NIL;
            end
            OP_SWAP0: lvl_reg <= '0;
            OP_LOAD_HEAD:
            begin
                sp_reg   <= hd;
                prev_reg <= NIL;
            end
            OP_LVL_INC: lvl_reg <= lvl_reg + LW'(1);
            OP_SET_INC:
            begin
                set_reg <= 1'b1;
                lvl_reg <= '0;
            end
            OP_SC_BLK:
            begin
                // A task blocked while running keeps the context it was stopped with.
                if (c_st == RS_RBLOCKED) sctx_reg[sp_i] <= ctx_reg;
                nx_reg        <= c_lk;
                stk_reg[sp_i] <= quant;
                sst_reg[sp_i] <= RS_BLOCKED;
                eq_reg        <= qidx(~bank_reg, lvl_reg);
            end
            OP_SC_NEXT: sp_reg <= nx_reg;
            OP_TK_UPD:
            begin
                if (c_st == RS_RUN)
                begin
                    if (c_tk != 8'd0) stk_reg[sp_i] <= c_tk - 8'd1;
                    sctx_reg[sp_i] <= ctx_reg;
                end
                else sst_reg[sp_i] <= RS_RUN;
            end
            OP_TK_EXP:
            begin
                stk_reg[sp_i] <= quant;
                sst_reg[sp_i] <= RS_READY;
                eq_reg        <= qidx(~bank_reg, lvl_reg);
            end
            OP_TK_END:
            begin
                if (sp_reg != NIL)
                begin
                    sst_reg[sp_i] <= RS_RUN;
                    rs_reg        <= ST_OK;
                    rid_reg       <= c_id;
                    rctx_reg      <= c_ctx;
                end
                else rs_reg <= ST_NONE;
            end
            OP_F_HIT:
            begin
                fset_reg <= set_reg;
                flvl_reg <= lvl_reg;
                fq_reg   <= qa;
            end
            OP_F_STEP:
            begin
                prev_reg <= sp_reg;
                sp_reg   <= c_lk;
            end
            OP_BLOCK:
            begin
                case (c_st)
                    RS_READY:
                    begin
                        sst_reg[sp_i] <= RS_BLOCKED;
                        rs_reg        <= ST_OK;
                    end
                    RS_BLOCKED:
                    begin
                        sst_reg[sp_i] <= RS_READY;
                        rs_reg        <= ST_OK;
                    end
                    RS_RUN:
                    begin
                        sst_reg[sp_i] <= RS_RBLOCKED;
                        rs_reg        <= ST_OK;
                        rres_reg      <= yld_reg;
                    end
                    default: ;
                endcase
            end
            OP_OK: rs_reg <= ST_OK;
            OP_NICE_EQ:
            begin
                rs_reg <= ST_OK;
                eq_reg <= qidx(bank_reg ^ fset_reg, nl);
            end
            OP_UNL_WR: if (prev_reg != NIL) slk_reg[prev_i] <= c_lk;
            OP_KILL_END:
            begin
                rs_reg   <= ST_OK;
                rres_reg <= (c_st == RS_RUN);
            end
            OP_LOAD_OUT:
            begin
                ost_reg  <= rs_reg;
                oid_reg  <= rid_reg;
                octx_reg <= rctx_reg;
                ores_reg <= rres_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        stat.func       = func_reg;
        stat.kself      = kself_reg;
        stat.nlev_ok    = (nlev_reg >= 8'(NICE_BASE)) &&
                          ({1'b0, nlev_reg} < 9'(NICE_BASE + PRIO_LEVELS));
        stat.run_nil    = (run_reg == NIL);
        stat.free_none  = (free_slot == NIL);
        stat.sp_nil     = (sp_reg == NIL);
        stat.sp_blocked = (c_st == RS_BLOCKED) || (c_st == RS_RBLOCKED);
        stat.sp_match   = ((func_reg == FN_KILL) && kself_reg) ? (sp_reg == run_reg)
                                                               : (c_id == tid_reg);
        stat.ticks_zero = (c_tk == 8'd0);
        stat.lvl_last   = (lvl_reg == LW'(PRIO_LEVELS - 1));
        stat.set_one    = set_reg;
        stat.nice_same  = (flvl_reg == nl);
        stat.hd_nil     = (hd == NIL);
        stat.out_busy   = ov_reg && !out_ready;
    end

    assign out_valid    = ov_reg;
    assign status       = ost_reg;
    assign result_id    = oid_reg;
    assign next_context = octx_reg;
    assign reschedule   = ores_reg;

endmodule

### sv/active_expired_priority_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// active_expired_priority_task_scheduler_unit
// Task scheduler with active and expired banks of FIFO priority queues.
// ----------------------------------------------------------------------------
// One item is processed at a time; the next is taken once the result is staged.
// Create claims a free slot and appends it to an active queue. Tick scans the queue
// levels (both banks when they swap), moves blocked heads to the expired set and
// re-queues the running task when it expires. Block, nice and kill search the queues
// and walk each chain task by task; kill then checks the active levels for a swap.
// One queue read a cycle. Reset clears all tables at once through valid bits.
module active_expired_priority_task_scheduler_unit #(
    parameter int MAX_TASKS   = aeps_pkg::MAX_TASKS_DEF,
    parameter int PRIO_LEVELS = aeps_pkg::PRIO_LEVELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [15:0] task_id,
    input  logic        kill_self,
    input  logic [63:0] context_word,
    input  logic [7:0]  nice_level,
    input  logic        yield_now,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] result_id,
    output logic [63:0] next_context,
    output logic        reschedule,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import aeps_pkg::*;

    dp_op_t   op;
    dp_stat_t stat;

    aeps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .op       (op)
    );

    aeps_dp #(
        .MAX_TASKS   (MAX_TASKS),
        .PRIO_LEVELS (PRIO_LEVELS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .stat         (stat),
        .func         (func),
        .task_id      (task_id),
        .kill_self    (kill_self),
        .context_word (context_word),
        .nice_level   (nice_level),
        .yield_now    (yield_now),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_id    (result_id),
        .next_context (next_context),
        .reschedule   (reschedule)
    );

    // A transfer in starts work, so the block is busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in progress");

    a_none_has_no_task: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NONE) |-> (result_id == 16'd0) && (next_context == 64'd0))
        else $error("nothing-runnable result carries a task");

    a_resched_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reschedule |-> status == ST_OK)
        else $error("reschedule flagged on a failed operation");

endmodule

### tb/sv/tb_active_expired_priority_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tb_active_expired_priority_task_scheduler_unit
// Self-checking bench: a table of directed operations followed by random
// scheduler traffic, every result compared against a behavioral scheduler.
// ----------------------------------------------------------------------------
module tb_active_expired_priority_task_scheduler_unit;
    import aeps_pkg::*;

    localparam int NT = MAX_TASKS_DEF;
    localparam int NL = PRIO_LEVELS_DEF;
    localparam logic [4:0] NIL = 5'(NT);
    localparam int WATCHDOG = 40000;
    localparam int N_RANDOM = 1730;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] tid;
        logic        kself;
        logic [63:0] ctx;
        logic [7:0]  nlev;
        logic        yld;
    } sched_op_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] rid;
        logic [63:0] nctx;
        logic        resched;
    } sched_res_t;

    typedef struct packed {
        logic       known;
        sched_op_t  op;
        sched_res_t res;
    } dir_row_t;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [2:0] func;
    logic [15:0] task_id;
    logic kill_self, yield_now;
    logic [63:0] context_word;
    logic [7:0] nice_level;
    logic [1:0] status;
    logic [15:0] result_id;
    logic [63:0] next_context;
    logic reschedule;
    logic cfg_we;
    logic [7:0] cfg_wdata;

    active_expired_priority_task_scheduler_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .task_id(task_id), .kill_self(kill_self),
        .context_word(context_word), .nice_level(nice_level), .yield_now(yield_now),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .result_id(result_id), .next_context(next_context),
        .reschedule(reschedule),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // Behavioral scheduler state.
    logic [7:0]  m_quantum;
    logic        m_valid [NT];
    logic [15:0] m_id [NT];
    run_state_t  m_state [NT];
    logic [7:0]  m_ticks [NT];
    logic [63:0] m_ctx [NT];
    logic [4:0]  m_link [NT];
    logic [4:0]  m_head [2*NL];
    logic [4:0]  m_tail [2*NL];
    logic        m_bank;
    logic [15:0] m_next_id;
    logic [7:0]  m_live;
    logic [4:0]  m_running;

    sched_res_t pending_results[$];
    int errors = 0;
    int idle_cycles = 0;
    int n_ticks = 0, n_none = 0, n_full = 0;
    logic quiet;

    function automatic int aq(int l); return int'(m_bank) * NL + l; endfunction
    function automatic int eq(int l); return int'(!m_bank) * NL + l; endfunction

    function automatic logic [7:0] grant(logic [15:0] id);
        int q;
        if (id == 0) q = 2 + 2 * m_live;
        else if (id == 1) q = 1;
        else if (id == 2) q = 2 + m_live;
        else q = m_quantum;
        return (q > 255) ? 8'hFF : 8'(q);
    endfunction

    task automatic push_tail(int q, logic [4:0] s);
        m_link[s] = NIL;
        if (m_tail[q] == NIL) m_head[q] = s;
        else m_link[m_tail[q]] = s;
        m_tail[q] = s;
    endtask

    task automatic drop_head(int q);
        logic [4:0] s;
        s = m_head[q];
        if (s != NIL)
        begin
            m_head[q] = m_link[s];
            if (m_head[q] == NIL) m_tail[q] = NIL;
        end
    endtask

    task automatic unlink(int q, logic [4:0] s);
        logic [4:0] prev, cur;
        int n;
        prev = NIL;
        cur = m_head[q];
        n = 0;
        while (cur != NIL && cur != s && n < NT)
        begin
            prev = cur;
            cur = m_link[cur];
            n++;
        end
        if (cur == s)
        begin
            if (prev == NIL) m_head[q] = m_link[cur];
            else m_link[prev] = m_link[cur];
            if (m_tail[q] == cur) m_tail[q] = prev;
        end
    endtask

    task automatic expire(logic [4:0] s, run_state_t st, int l);
        m_ticks[s] = grant(m_id[s]);
        m_state[s] = st;
        push_tail(eq(l), s);
    endtask

    // Walk active levels from start; blocked heads are moved to the expired set.
    task automatic pick_runnable(int start, logic [63:0] ctx, output logic [4:0] s,
                                 inout int lvl);
        int q;
        s = NIL;
        for (int l = start; l < NL; l++)
        begin
            q = aq(l);
            s = m_head[q];
            while (s != NIL && m_state[s] >= RS_BLOCKED)
            begin
                if (m_state[s] == RS_RBLOCKED) m_ctx[s] = ctx;
                drop_head(q);
                expire(s, RS_BLOCKED, l);
                s = m_head[q];
            end
            if (s != NIL)
            begin
                lvl = l;
                return;
            end
        end
    endtask

    function automatic logic [4:0] locate(logic [15:0] id, logic [4:0] slot, logic by_slot,
                                          output int q_o, output int l_o);
        int q, n;
        logic [4:0] s;
        q_o = 0;
        l_o = 0;
        for (int set = 0; set < 2; set++)
            for (int l = 0; l < NL; l++)
            begin
                q = set ? eq(l) : aq(l);
                s = m_head[q];
                for (n = 0; s != NIL && n < NT; n++)
                begin
                    if (by_slot ? (s == slot) : (m_id[s] == id))
                    begin
                        q_o = q;
                        l_o = l;
                        return s;
                    end
                    s = m_link[s];
                end
            end
        return NIL;
    endfunction

    task automatic model_reset();
        m_quantum = DEF_QUANTUM;
        for (int i = 0; i < NT; i++)
        begin
            m_valid[i] = 0; m_id[i] = 0; m_state[i] = RS_READY;
            m_ticks[i] = 0; m_ctx[i] = 0; m_link[i] = NIL;
        end
        for (int i = 0; i < 2*NL; i++)
        begin
            m_head[i] = NIL; m_tail[i] = NIL;
        end
        m_bank = 0; m_next_id = 0; m_live = 0; m_running = NIL;
    endtask

    task automatic schedule_op(sched_op_t op, output sched_res_t r);
        logic [4:0] s;
        int q, lvl;
        logic empty;
        run_state_t st;
        r = '0;
        r.status = ST_IGNORED;
        q = 0;
        lvl = 0;
        case (op.func)
            FN_CREATE:
            begin
                s = NIL;
                for (int i = NT - 1; i >= 0; i--)
                    if (!m_valid[i]) s = 5'(i);
                if (s == NIL) r.status = ST_FULL;
                else
                begin
                    m_valid[s] = 1;
                    m_id[s] = m_next_id;
                    m_next_id = m_next_id + 16'd1;
                    m_ctx[s] = op.ctx;
                    m_ticks[s] = grant(m_id[s]);
                    m_state[s] = RS_READY;
                    push_tail(aq(0), s);
                    m_live = m_live + 8'd1;
                    r.status = ST_OK;
                    r.rid = m_id[s];
                end
            end
            FN_TICK:
            begin
                pick_runnable(0, op.ctx, s, lvl);
                if (s == NIL)
                begin
                    m_bank = !m_bank;
                    pick_runnable(0, op.ctx, s, lvl);
                end
                if (s != NIL)
                begin
                    if (m_state[s] == RS_RUN)
                    begin
                        if (m_ticks[s] > 0) m_ticks[s] = m_ticks[s] - 8'd1;
                        m_ctx[s] = op.ctx;
                    end
                    else m_state[s] = RS_RUN;
                    if (m_ticks[s] == 0)
                    begin
                        drop_head(aq(lvl));
                        expire(s, RS_READY, lvl);
                        pick_runnable(lvl, op.ctx, s, lvl);
                        if (s == NIL)
                        begin
                            m_bank = !m_bank;
                            pick_runnable(0, op.ctx, s, lvl);
                        end
                        if (s != NIL) m_state[s] = RS_RUN;
                    end
                end
                m_running = s;
                if (s == NIL) r.status = ST_NONE;
                else
                begin
                    r.status = ST_OK;
                    r.rid = m_id[s];
                    r.nctx = m_ctx[s];
                end
            end
            FN_BLOCK:
            begin
                s = locate(op.tid, 0, 0, q, lvl);
                if (s != NIL)
                begin
                    st = m_state[s];
                    r.status = ST_OK;
                    if (st == RS_READY) m_state[s] = RS_BLOCKED;
                    else if (st == RS_BLOCKED) m_state[s] = RS_READY;
                    else if (st == RS_RUN)
                    begin
                        m_state[s] = RS_RBLOCKED;
                        r.resched = op.yld;
                    end
                    else r.status = ST_IGNORED;
                end
            end
            FN_NICE:
            begin
                if (op.nlev >= NICE_BASE && op.nlev < NICE_BASE + NL)
                begin
                    s = locate(op.tid, 0, 0, q, lvl);
                    if (s != NIL)
                    begin
                        r.status = ST_OK;
                        if (lvl != op.nlev - NICE_BASE)
                        begin
                            empty = ((q / NL) == int'(m_bank));
                            unlink(q, s);
                            push_tail(empty ? aq(op.nlev - NICE_BASE)
                                            : eq(op.nlev - NICE_BASE), s);
                        end
                    end
                end
            end
            FN_KILL:
            begin
                if (op.kself)
                    s = (m_running != NIL) ? locate(0, m_running, 1, q, lvl) : NIL;
                else
                    s = locate(op.tid, 0, 0, q, lvl);
                if (s != NIL)
                begin
                    unlink(q, s);
                    empty = 1;
                    for (int l = 0; l < NL; l++)
                        if (m_head[aq(l)] != NIL) empty = 0;
                    if (empty) m_bank = !m_bank;
                    if (m_state[s] == RS_RUN) r.resched = 1;
                    m_valid[s] = 0;
                    if (m_live > 0) m_live = m_live - 8'd1;
                    if (m_running == s) m_running = NIL;
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
    endtask

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Result side: random back-pressure, compare each transfer with the oldest prediction.
    initial
    begin
        int stall;
        sched_res_t exp_r;
        out_ready = 0;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected result: actual %h/%h/%h/%b", $time,
                             status, result_id, next_context, reschedule);
                    errors++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (status !== exp_r.status)
                    begin
                        $display("%0t status expected %0d actual %0d", $time, exp_r.status, status);
                        errors++;
                    end
                    if (result_id !== exp_r.rid)
                    begin
                        $display("%0t result_id expected %h actual %h", $time, exp_r.rid, result_id);
                        errors++;
                    end
                    if (next_context !== exp_r.nctx)
                    begin
                        $display("%0t next_context expected %h actual %h", $time,
                                 exp_r.nctx, next_context);
                        errors++;
                    end
                    if (reschedule !== exp_r.resched)
                    begin
                        $display("%0t reschedule expected %b actual %b", $time,
                                 exp_r.resched, reschedule);
                        errors++;
                    end
                end
            end
            if (stall > 0)
                stall--;
            else if (!quiet && $urandom_range(0, 9) == 0)
                stall = $urandom_range(1, 15);
            out_ready <= (stall == 0);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("%0t watchdog expired, %0d results outstanding", $time,
                     pending_results.size());
            $display("[active_expired_priority_task_scheduler_unit] ERROR");
            $finish;
        end
    end

    task automatic send(sched_op_t op, logic known, sched_res_t want);
        sched_res_t r;
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge clk);
        end
        schedule_op(op, r);
        if (known && r !== want)
        begin
            $display("%0t table row mismatch: expected %h actual %h", $time, want, r);
            errors++;
        end
        if (op.func == FN_TICK) n_ticks++;
        if (r.status == ST_NONE) n_none++;
        if (r.status == ST_FULL) n_full++;
        pending_results.push_back(r);
        func <= op.func; task_id <= op.tid; kill_self <= op.kself;
        context_word <= op.ctx; nice_level <= op.nlev; yield_now <= op.yld;
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        in_valid <= 0;
        // The block is busy after a transfer, so this edge costs no throughput.
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_quantum(logic [7:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        m_quantum = v;
    endtask

    function automatic logic [15:0] pick_id();
        int s;
        s = $urandom_range(0, NT - 1);
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        if (m_valid[s]) return m_id[s];
        return m_next_id - 16'($urandom_range(1, 20));
    endfunction

    function automatic sched_op_t random_op();
        sched_op_t op;
        int k;
        op.tid = pick_id();
        op.kself = 1'($urandom_range(0, 1));
        op.ctx = {$urandom, $urandom};
        op.nlev = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(100, 139));
        op.yld = 1'($urandom_range(0, 1));
        k = $urandom_range(0, 99);
        if (k < 20) op.func = FN_CREATE;
        else if (k < 55) op.func = FN_TICK;
        else if (k < 70) op.func = FN_BLOCK;
        else if (k < 83) op.func = FN_NICE;
        else if (k < 97) op.func = FN_KILL;
        else op.func = 3'($urandom_range(5, 7));
        return op;
    endfunction

    function automatic dir_row_t row(logic known, logic [2:0] f, logic [15:0] tid,
                                     logic ks, logic [63:0] ctx, logic [7:0] nl, logic y,
                                     logic [1:0] st, logic [15:0] rid, logic [63:0] nctx,
                                     logic rs);
        dir_row_t d;
        d.known = known;
        d.op = '{f, tid, ks, ctx, nl, y};
        d.res = '{st, rid, nctx, rs};
        return d;
    endfunction

    dir_row_t dir_table[$];

    initial
    begin
        sched_op_t op;
        sched_res_t none_r;
        rst_n = 0; in_valid = 0; out_ready = 0; cfg_we = 0; cfg_wdata = 0;
        func = 0; task_id = 0; kill_self = 0; context_word = 0; nice_level = 0; yield_now = 0;
        quiet = 0;
        none_r = '0;
        model_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed rows: empty scheduler, extremes of fields, each operation.
        dir_table.push_back(row(1, FN_TICK, 0, 0, '1, 0, 0, ST_NONE, 0, 0, 0));
        dir_table.push_back(row(1, FN_KILL, 0, 1, 0, 0, 0, ST_IGNORED, 0, 0, 0));
        dir_table.push_back(row(1, FN_BLOCK, 16'hFFFF, 0, 0, 0, 1, ST_IGNORED, 0, 0, 0));
        dir_table.push_back(row(1, 3'd7, 16'hFFFF, 1, '1, 8'hFF, 1, ST_IGNORED, 0, 0, 0));
        dir_table.push_back(row(1, 3'd5, 0, 0, 0, 0, 0, ST_IGNORED, 0, 0, 0));
        dir_table.push_back(row(1, FN_CREATE, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0,
                                ST_OK, 0, 0, 0));
        dir_table.push_back(row(1, FN_CREATE, 0, 0, 0, 0, 0, ST_OK, 1, 0, 0));
        dir_table.push_back(row(1, FN_CREATE, 0, 0, 64'h5555_AAAA_5555_AAAA, 0, 0,
                                ST_OK, 2, 0, 0));
        dir_table.push_back(row(1, FN_CREATE, 0, 0, 64'h1234, 0, 0, ST_OK, 3, 0, 0));
        dir_table.push_back(row(1, FN_TICK, 0, 0, 64'hAAAA, 0, 0, ST_OK, 0, '1, 0));
        dir_table.push_back(row(0, FN_TICK, 0, 0, 64'hBBBB, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(row(0, FN_BLOCK, 1, 0, 0, 0, 1, 0, 0, 0, 0));
        dir_table.push_back(row(0, FN_BLOCK, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(row(0, FN_TICK, 0, 0, 64'hCCCC, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(row(1, FN_NICE, 2, 0, 0, 8'd99, 0, ST_IGNORED, 0, 0, 0));
        dir_table.push_back(row(1, FN_NICE, 2, 0, 0, 8'd140, 0, ST_IGNORED, 0, 0, 0));
        dir_table.push_back(row(0, FN_NICE, 2, 0, 0, 8'd139, 0, 0, 0, 0, 0));
        dir_table.push_back(row(0, FN_NICE, 3, 0, 0, 8'd100, 0, 0, 0, 0, 0));
        dir_table.push_back(row(0, FN_TICK, 0, 0, 64'hDDDD, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(row(0, FN_KILL, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(row(0, FN_KILL, 3, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(row(1, FN_KILL, 16'hFFFF, 0, 0, 0, 0, ST_IGNORED, 0, 0, 0));
        foreach (dir_table[i])
            send(dir_table[i].op, dir_table[i].known, dir_table[i].res);
        // Fill the table to test the full answer.
        for (int i = 0; i < NT; i++)
        begin
            op = '{FN_CREATE, 0, 0, {$urandom, $urandom}, 0, 0};
            send(op, 0, none_r);
        end

        // Random phases across several quanta, extremes included.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_quantum(8'd1);
                1: write_quantum(8'd255);
                2: write_quantum(8'($urandom_range(1, 8)));
                3: write_quantum(8'd3);
                4: write_quantum(8'($urandom_range(1, 255)));
                default: write_quantum(8'd2);
            endcase
            if (ph == 5) quiet = 1;
            for (int i = 0; i < N_RANDOM / 6; i++)
                send(random_op(), 0, none_r);
        end

        drain();
        $display("Covered %0d ticks, %0d idle answers, %0d full answers, six quantum settings.",
                 n_ticks, n_none, n_full);
        if (errors == 0)
            $display("[active_expired_priority_task_scheduler_unit] OK");
        else
            $display("[active_expired_priority_task_scheduler_unit] ERROR");
        $finish;
    end
endmodule
